// ===== rtl/core/kti_pkg.sv =====
// ---------------------------------------------------------------------------
// kti_pkg: shared types for the keyframe table interpolator
// Controller states, datapath command and status bundles, field widths.
// ---------------------------------------------------------------------------
package kti_pkg;

    localparam int VAL_W  = 32;
    localparam int NCOMP  = 4;
    localparam int WORD_W = VAL_W * (NCOMP + 1);
    localparam int DVD_W  = 2 * VAL_W + 1;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_SH_CHK,
        S_SH_WR,
        S_Q_RDN,
        S_Q_CAPN,
        S_DIFF,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        ADDR_INIT,
        ADDR_IDX,
        ADDR_IDXM1,
        ADDR_PREV,
        ADDR_NEXT,
        ADDR_POS
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_INIT,
        WD_SHIFT,
        WD_NEW,
        WD_UPD
    } t_wd_sel;

    typedef struct packed {
        logic      in_ready;
        logic      out_valid;
        logic      load;
        logic      init_wr;
        logic      init_inc;
        logic      idx_inc;
        logic      idx_dec;
        logic      idx_ld_cnt;
        logic      scan_upd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        logic      cnt_inc;
        logic      set_full;
        logic      cap_vp;
        logic      cap_vn;
        logic      res_vp;
        logic      comp_clr;
        logic      comp_inc;
        logic      diff_ld;
        logic      mul_ld;
        logic      div_start;
        logic      res_ld;
    } t_cmd;

    typedef struct packed {
        logic bad_tab;
        logic op;
        logic scan_gt;
        logic scan_last;
        logic need_ins;
        logic full;
        logic sh_more;
        logic same;
        logic div_done;
        logic comp_last;
        logic init_last;
    } t_sts;

endpackage

// ===== rtl/core/keyframe_table_interpolator_top.sv =====
// ---------------------------------------------------------------------------
// keyframe_table_interpolator_top: keyframe tables with linear interpolation
// Sorted per-type key tables; set and insert keys, query interpolated values.
// ---------------------------------------------------------------------------
// One request at a time, one result per request. A set scans the keys in turn
// (read, then compare) and on an insert moves each later key up (check, then
// write); a query takes the scan, reads both neighbours and, between two keys,
// runs the shared one-bit-per-cycle divider once per component. After reset
// the block seeds the first key of each table before it takes a request.
// Values are signed Q16.16; offsets round half away from zero.
// ---------------------------------------------------------------------------
module keyframe_table_interpolator_top
    import kti_pkg::*;
#(
    parameter int NUM_TABLES = 4,
    parameter int MAX_KEYS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [159:0] i_s_axis_tdata,  // frame_time, value_x, value_y, value_z, value_w
    input  logic [3:0]   i_s_axis_tuser,  // op, add_key, key_type[1:0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,  // result_x, result_y, result_z, result_w
    output logic [0:0]   o_m_axis_tuser   // status
);

    t_cmd w_cmd;
    t_sts w_sts;

    kti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    kti_datapath #(
        .NUM_TABLES (NUM_TABLES),
        .MAX_KEYS   (MAX_KEYS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (i_s_axis_tuser[0]),
        .i_add_key    (i_s_axis_tuser[1]),
        .i_key_type   (i_s_axis_tuser[3:2]),
        .i_frame_time (i_s_axis_tdata[31:0]),
        .i_values     (i_s_axis_tdata[159:32]),
        .o_status     (o_m_axis_tuser[0]),
        .o_results    (o_m_axis_tdata)
    );

    assign o_s_axis_tready = w_cmd.in_ready;
    assign o_m_axis_tvalid = w_cmd.out_valid;

endmodule

// ===== rtl/core/kti_div.sv =====
// ---------------------------------------------------------------------------
// kti_div: restoring divider
// One quotient bit per cycle; keeps the low quotient bits only.
// ---------------------------------------------------------------------------
module kti_div
    import kti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [VAL_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [VAL_W-1:0]   o_quotient
);

    localparam int SW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [SW-1:0]    r_step;
    logic [DVD_W-1:0] r_dvd;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_quo;
    logic [VAL_W-1:0] r_den;
    logic [VAL_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= SW'(DVD_W);
        end else if (r_busy && r_step != '0) begin
            r_step <= r_step - 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy && r_step != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_ge ? VAL_W'(w_sh - {1'b0, r_den}) : w_sh[VAL_W-1:0];
            r_quo <= {r_quo[VAL_W-2:0], w_ge};
        end
    end

    assign o_done     = r_busy && (r_step == '0);
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/kti_datapath.sv =====
// ---------------------------------------------------------------------------
// kti_datapath: key memory, table counts and interpolation arithmetic
// Executes controller commands; reports compare results back.
// ---------------------------------------------------------------------------
module kti_datapath
    import kti_pkg::*;
#(
    parameter int NUM_TABLES = 4,
    parameter int MAX_KEYS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_op,
    input  logic                 i_add_key,
    input  logic [1:0]           i_key_type,
    input  logic [VAL_W-1:0]     i_frame_time,
    input  logic [NCOMP*VAL_W-1:0] i_values,
    output logic                 o_status,
    output logic [NCOMP*VAL_W-1:0] o_results
);

    localparam int DEPTH = NUM_TABLES * MAX_KEYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int IW    = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd;

    logic               r_op;
    logic               r_add;
    logic               r_bad;
    logic [TW-1:0]      r_tab;
    logic [TW-1:0]      r_init;
    logic [VAL_W-1:0]   r_tm;
    logic [NCOMP*VAL_W-1:0] r_val;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_prev;
    logic [IW-1:0]      r_next;
    logic [VAL_W-1:0]   r_tprev;
    logic [CW-1:0]      r_cnt [NUM_TABLES];
    logic [VAL_W-1:0]   r_vp [NCOMP];
    logic [VAL_W-1:0]   r_vn [NCOMP];
    logic [VAL_W-1:0]   r_num;
    logic [VAL_W-1:0]   r_den;
    logic [1:0]         r_comp;
    logic               r_neg;
    logic [VAL_W-1:0]   r_mag;
    logic [2*VAL_W-1:0] r_prod;
    logic [VAL_W-1:0]   r_res [NCOMP];
    logic               r_status;

    logic [CW-1:0]      w_n;
    logic [IW-1:0]      w_pos;
    logic [AW-1:0]      w_base;
    logic [AW-1:0]      w_addr;
    logic [WORD_W-1:0]  w_wd;
    logic [VAL_W:0]     w_diff;
    logic               w_div_done;
    logic [VAL_W-1:0]   w_quo;
    logic [VAL_W-1:0]   w_vp_c;

    assign w_n    = r_cnt[r_tab];
    assign w_pos  = (r_tprev < r_tm) ? r_prev + 1'b1 : r_prev;
    assign w_base = AW'(r_tab) * AW'(MAX_KEYS);
    assign w_vp_c = r_vp[r_comp];
    assign w_diff = {r_vn[r_comp][VAL_W-1], r_vn[r_comp]} - {w_vp_c[VAL_W-1], w_vp_c};

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_INIT:  w_addr = AW'(r_init) * AW'(MAX_KEYS);
            ADDR_IDX:   w_addr = w_base + AW'(r_idx);
            ADDR_IDXM1: w_addr = w_base + AW'(r_idx - 1'b1);
            ADDR_PREV:  w_addr = w_base + AW'(r_prev);
            ADDR_NEXT:  w_addr = w_base + AW'(r_next);
            ADDR_POS:   w_addr = w_base + AW'(w_pos);
            default:    w_addr = w_base;
        endcase
    end

    always_comb begin
        case (i_cmd.wd_sel)
            WD_INIT:  w_wd = WORD_W'(1);
            WD_SHIFT: w_wd = r_rd;
            WD_NEW:   w_wd = {r_val, r_tm};
            WD_UPD:   w_wd = {r_val, r_tprev};
            default:  w_wd = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr || i_cmd.init_wr) begin
            mem[w_addr] <= w_wd;
        end
        r_rd <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_cnt[t] <= CW'(1);
            end
        end else begin
            if (i_cmd.init_inc) begin
                r_init <= r_init + 1'b1;
            end
            if (i_cmd.cnt_inc) begin
                r_cnt[r_tab] <= w_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_add    <= i_add_key;
            r_bad    <= (32'(i_key_type) >= 32'(NUM_TABLES));
            r_tab    <= TW'(i_key_type);
            r_tm     <= i_frame_time;
            r_val    <= i_values;
            r_idx    <= '0;
            r_prev   <= '0;
            r_next   <= '0;
            r_status <= 1'b0;
            for (int c = 0; c < NCOMP; c++) begin
                r_res[c] <= '0;
            end
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.idx_dec) begin
                r_idx <= r_idx - 1'b1;
            end
            if (i_cmd.idx_ld_cnt) begin
                r_idx <= IW'(w_n);
            end
            if (i_cmd.scan_upd) begin
                r_next <= r_idx;
                if (r_rd[VAL_W-1:0] <= r_tm) begin
                    r_prev <= r_idx;
                end
                if (r_rd[VAL_W-1:0] <= r_tm || r_idx == '0) begin
                    r_tprev <= r_rd[VAL_W-1:0];
                end
            end
            if (i_cmd.set_full) begin
                r_status <= 1'b1;
            end
            if (i_cmd.cap_vp) begin
                for (int c = 0; c < NCOMP; c++) begin
                    r_vp[c] <= r_rd[(c+1)*VAL_W +: VAL_W];
                end
                r_num <= r_tm - r_tprev;
            end
            if (i_cmd.cap_vn) begin
                for (int c = 0; c < NCOMP; c++) begin
                    r_vn[c] <= r_rd[(c+1)*VAL_W +: VAL_W];
                end
                r_den <= r_rd[VAL_W-1:0] - r_tprev;
            end
            if (i_cmd.res_vp) begin
                for (int c = 0; c < NCOMP; c++) begin
                    r_res[c] <= r_vp[c];
                end
            end
            if (i_cmd.comp_clr) begin
                r_comp <= '0;
            end
            if (i_cmd.comp_inc) begin
                r_comp <= r_comp + 1'b1;
            end
            if (i_cmd.diff_ld) begin
                r_neg <= w_diff[VAL_W];
                r_mag <= w_diff[VAL_W] ? VAL_W'(-w_diff) : w_diff[VAL_W-1:0];
            end
            if (i_cmd.mul_ld) begin
                r_prod <= r_mag * r_num;
            end
            if (i_cmd.res_ld) begin
                r_res[r_comp] <= r_neg ? w_vp_c - w_quo : w_vp_c + w_quo;
            end
        end
    end

    kti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({1'b0, r_prod} + DVD_W'(r_den >> 1)),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        o_sts.bad_tab   = r_bad;
        o_sts.op        = r_op;
        o_sts.scan_gt   = (r_rd[VAL_W-1:0] > r_tm);
        o_sts.scan_last = ((CW'(r_idx) + 1'b1) == w_n);
        o_sts.need_ins  = r_add && (r_tprev != r_tm);
        o_sts.full      = (w_n >= CW'(MAX_KEYS));
        o_sts.sh_more   = (r_idx > w_pos);
        o_sts.same      = (r_prev == r_next);
        o_sts.div_done  = w_div_done;
        o_sts.comp_last = (r_comp == 2'(NCOMP - 1));
        o_sts.init_last = (r_init == TW'(NUM_TABLES - 1));
    end

    assign o_status = r_status;
    assign o_results = {r_res[3], r_res[2], r_res[1], r_res[0]};

endmodule

// ===== rtl/core/kti_ctrl.sv =====
// ---------------------------------------------------------------------------
// kti_ctrl: sequencing state machine
// Steps through init, table scan, insert shift and interpolation.
// ---------------------------------------------------------------------------
module kti_ctrl
    import kti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     if (i_sts.init_last) n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) n_state = S_SCAN_RD;
            S_SCAN_RD: begin
                n_state = i_sts.bad_tab ? S_OUT : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                n_state = (i_sts.scan_gt || i_sts.scan_last) ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE: begin
                if (i_sts.op == OP_QUERY) begin
                    n_state = S_Q_RDN;
                end else if (i_sts.need_ins && !i_sts.full) begin
                    n_state = S_SH_CHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SH_CHK:   n_state = i_sts.sh_more ? S_SH_WR : S_OUT;
            S_SH_WR:    n_state = S_SH_CHK;
            S_Q_RDN:    n_state = S_Q_CAPN;
            S_Q_CAPN:   n_state = i_sts.same ? S_OUT : S_DIFF;
            S_DIFF:     n_state = S_MUL;
            S_MUL:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.comp_last ? S_OUT : S_DIFF;
                end
            end
            S_OUT:      if (i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_IDX;
        o_cmd.wd_sel   = WD_SHIFT;
        case (r_state)
            S_INIT: begin
                o_cmd.addr_sel = ADDR_INIT;
                o_cmd.wd_sel   = WD_INIT;
                o_cmd.init_wr  = 1'b1;
                o_cmd.init_inc = !i_sts.init_last;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_upd = 1'b1;
                o_cmd.idx_inc  = !(i_sts.scan_gt || i_sts.scan_last);
            end
            S_DECIDE: begin
                o_cmd.addr_sel = ADDR_PREV;
                if (i_sts.op == OP_SET) begin
                    if (i_sts.need_ins) begin
                        o_cmd.set_full   = i_sts.full;
                        o_cmd.idx_ld_cnt = !i_sts.full;
                    end else begin
                        o_cmd.wd_sel = WD_UPD;
                        o_cmd.mem_wr = 1'b1;
                    end
                end
            end
            S_SH_CHK: begin
                if (i_sts.sh_more) begin
                    o_cmd.addr_sel = ADDR_IDXM1;
                end else begin
                    o_cmd.addr_sel = ADDR_POS;
                    o_cmd.wd_sel   = WD_NEW;
                    o_cmd.mem_wr   = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                end
            end
            S_SH_WR: begin
                o_cmd.mem_wr  = 1'b1;
                o_cmd.idx_dec = 1'b1;
            end
            S_Q_RDN: begin
                o_cmd.addr_sel = ADDR_NEXT;
                o_cmd.cap_vp   = 1'b1;
            end
            S_Q_CAPN: begin
                o_cmd.cap_vn   = 1'b1;
                o_cmd.res_vp   = i_sts.same;
                o_cmd.comp_clr = 1'b1;
            end
            S_DIFF:     o_cmd.diff_ld = 1'b1;
            S_MUL:      o_cmd.mul_ld = 1'b1;
            S_DIV_GO:   o_cmd.div_start = 1'b1;
            S_DIV_WAIT: begin
                o_cmd.res_ld   = i_sts.div_done;
                o_cmd.comp_inc = i_sts.div_done && !i_sts.comp_last;
            end
            S_OUT:      o_cmd.out_valid = 1'b1;
            default:    o_cmd.in_ready = 1'b0;
        endcase
    end

endmodule
